// File: rtl/kcl_pkg.sv
package kcl_pkg;

  localparam int SAMPLE_W = 12;
  localparam int POS_W = 4;
  localparam int COUNT_W = 3;
  localparam int PASS_W = 24;
  localparam int HOLD_W = 4;
  localparam int CFG_W = 24;

  localparam logic [POS_W-1:0] NO_CODE = 4'd15;

  localparam logic [PASS_W-1:0] PASSWORD_RESET = 24'd7501831;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 4'd10;

  // Configuration register indexes.
  localparam logic REG_PASSWORD = 1'b0;
  localparam logic REG_HOLD = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_ADD     = 3'd1,
    EV_REPEAT  = 3'd2,
    EV_CLEAR   = 3'd3,
    EV_OPEN    = 3'd4,
    EV_RELOCK  = 3'd5
  } event_t;

  typedef enum logic {
    LOCKED   = 1'b0,
    UNLOCKED = 1'b1
  } lock_state_t;

endpackage

// File: rtl/knob_combination_lock.sv
// Knob combination lock.
// The s_ stream carries one knob sample per word (s_tdata[11:0]); the m_
// stream returns one status word per sample: open flag, quantized position,
// number of codes entered and the event caused by that sample.
// The password and the hold count are written through the cfg_ port while
// no sample is in flight; a write takes effect at the clock edge that sees
// cfg_write high.
// A sample accepted on the s_ stream lands in the input register, and its
// result is loaded into the output register once that register is free,
// that is when m_tready is high or no result word is waiting.
// Throughput: one sample per cycle while m_tready is high. The quantizer
// compares and the lock update are a single pass of logic between the
// input register and the output register, and the lock state is written
// back at the same edge. When the receiver holds m_tready low, the output
// word and the input register both hold and s_tready drops once the input
// register is full. Reset clears both valid flags, locks the lock, empties
// the entry and restores the default password and hold count.
module knob_combination_lock #(
  parameter int NUM_POSITIONS = 13,
  parameter int STEP_SIZE = 315,
  parameter int CODE_LENGTH = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] knob_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] is_open, [4:1] knob_position, [7:5] entered_count, [10:8] event_code
  output logic [15:0] m_tdata,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [kcl_pkg::CFG_W-1:0] cfg_data
);
  import kcl_pkg::*;

  localparam logic [POS_W-1:0] ZERO_POS = POS_W'(NUM_POSITIONS / 2);
  localparam logic [COUNT_W-1:0] CODE_LEN_C = COUNT_W'(CODE_LENGTH);

  // Configuration.
  logic [PASS_W-1:0] password_codes;
  logic [HOLD_W-1:0] hold_count;

  // Pipeline.
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                out_valid;
  logic                is_open;
  logic [POS_W-1:0]    knob_position;
  logic [COUNT_W-1:0]  entered_count;
  event_t              event_code;
  logic                out_free;
  logic                advance;

  // Lock state.
  lock_state_t        state, state_next;
  logic [HOLD_W-1:0]  hold_counter, hold_counter_next;
  logic [POS_W-1:0]   held_code, held_code_next;
  logic [POS_W-1:0]   previous_code, previous_code_next;
  logic [COUNT_W-1:0] entry_count, entry_count_next;
  logic [POS_W-1:0]   entered_codes [CODE_LENGTH];

  // Decode.
  logic [POS_W-1:0]  pos;
  logic [HOLD_W-1:0] need;
  logic [HOLD_W-1:0] hc_inc;
  logic              zero;
  logic              reached;
  logic              hit;
  logic              confirmed;
  logic              full;
  logic              code_match;
  event_t            ev;

  assign out_free = !out_valid || m_tready;
  assign advance  = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      password_codes <= PASSWORD_RESET;
      hold_count <= HOLD_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_PASSWORD) begin
        password_codes <= cfg_data[PASS_W-1:0];
      end else begin
        hold_count <= cfg_data[HOLD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_sample <= s_tdata[SAMPLE_W-1:0];
    end
  end

  // The first position whose upper threshold covers the sample wins; a
  // sample above every threshold saturates at the top position.
  always_comb begin
    pos = POS_W'(NUM_POSITIONS - 1);
    for (int p = NUM_POSITIONS - 1; p >= 0; p--) begin
      if (32'(s1_sample) <= 32'(STEP_SIZE * (p + 1))) begin
        pos = POS_W'(p);
      end
    end
  end

  always_comb begin
    code_match = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (entered_codes[i] != password_codes[4*i +: 4]) begin
        code_match = 1'b0;
      end
    end
  end

  assign need      = (hold_count == '0) ? HOLD_W'(1) : hold_count;
  assign hc_inc    = hold_counter + HOLD_W'(1);
  assign zero      = (pos == ZERO_POS);
  assign reached   = (hc_inc >= need);
  assign hit       = (state == UNLOCKED) ? zero : (zero || pos == held_code);
  assign confirmed = (state == LOCKED) && hit && reached;
  assign full      = (entry_count >= CODE_LEN_C);

  always_comb begin
    state_next = state;
    unique case (state)
      LOCKED: begin
        if (confirmed && full && code_match) begin
          state_next = UNLOCKED;
        end
      end
      UNLOCKED: begin
        if (zero && reached) begin
          state_next = LOCKED;
        end
      end
      default: state_next = LOCKED;
    endcase
  end

  always_comb begin
    ev = EV_NONE;
    unique case (state)
      LOCKED: begin
        if (confirmed) begin
          if (full) begin
            ev = code_match ? EV_OPEN : EV_CLEAR;
          end else if (zero) begin
            ev = EV_CLEAR;
          end else if (pos != previous_code) begin
            ev = EV_ADD;
          end else begin
            ev = EV_REPEAT;
          end
        end
      end
      UNLOCKED: begin
        if (zero && reached) begin
          ev = EV_RELOCK;
        end
      end
      default: ev = EV_NONE;
    endcase
  end

  always_comb begin
    hold_counter_next  = (hit && !reached) ? hc_inc : '0;
    held_code_next     = (state == LOCKED) ? pos : held_code;
    previous_code_next = previous_code;
    entry_count_next   = entry_count;
    case (ev) inside
      EV_CLEAR, EV_RELOCK: begin
        held_code_next     = NO_CODE;
        previous_code_next = NO_CODE;
        entry_count_next   = '0;
      end
      EV_ADD: begin
        previous_code_next = pos;
        entry_count_next   = entry_count + COUNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOCKED;
      hold_counter <= '0;
      held_code <= NO_CODE;
      previous_code <= NO_CODE;
      entry_count <= '0;
    end else if (advance) begin
      state <= state_next;
      hold_counter <= hold_counter_next;
      held_code <= held_code_next;
      previous_code <= previous_code_next;
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (advance && ev == EV_ADD && entry_count == COUNT_W'(i)) begin
        entered_codes[i] <= pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      is_open <= (state_next == UNLOCKED);
      knob_position <= pos;
      entered_count <= entry_count_next;
      event_code <= ev;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, event_code, entered_count, knob_position, is_open};

  a_entry_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CODE_LEN_C)
    else $error("entry count ran past the code length");

  a_open_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_code == EV_OPEN) |-> is_open)
    else $error("open event without the open flag");

  a_relock_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && ev == EV_RELOCK) |=> (state == LOCKED && entry_count == '0))
    else $error("relock did not lock and clear the entry");

endmodule
